>>> rtl/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_BITS    = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int OUT_CNT_W   = 6;
    localparam int OUT_CNT_MAX = (2 ** OUT_CNT_W) - 1;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_PRESENT = 2'd2;
    localparam logic [ST_W-1:0] ST_ABSENT  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [VAL_W-1:0]    value;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic                 found;
        logic [VAL_W-1:0]     read_value;
        logic [OUT_CNT_W-1:0] match_count;
        logic [OUT_CNT_W-1:0] occupancy;
    } result_t;

    function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        logic [OUT_CNT_W-1:0] r;
        if (32'(v) > OUT_CNT_MAX) begin
            r = OUT_CNT_W'(OUT_CNT_MAX);
        end else begin
            r = OUT_CNT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/kvt_ram.sv
`default_nettype none

module kvt_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/kvt_ctrl.sv
`default_nettype none

module kvt_ctrl import kvt_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OP_W-1:0]     in_op,
    input  wire logic [KEY_BITS-1:0] in_key,
    input  wire logic [VAL_W-1:0]    in_value,
    output mem_req_t                 mem_req,
    input  wire entry_t              mem_rdata,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output result_t                  res
);

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [ADDR_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]    match_reg, match_next;
    logic [CNT_W-1:0]    sh_rd_reg, sh_rd_next;
    logic                sh_pend_reg, sh_pend_next;
    logic [ADDR_W-1:0]   sh_wa_reg, sh_wa_next;
    result_t             res_reg, res_next;

    logic             hit_now;
    logic             val_hit;
    logic             scan_more;
    logic             shift_more;
    logic [CNT_W-1:0] match_sum;
    logic [CNT_W-1:0] hit_next_slot;

    // compare stage sees the entry read in the previous cycle
    assign hit_now    = cmp_vld_reg && (op_reg != OP_COUNT) && (mem_rdata.key == key_reg);
    assign val_hit    = cmp_vld_reg && (op_reg == OP_COUNT) && (mem_rdata.value == val_reg);
    assign scan_more  = rd_idx_reg < count_reg;
    assign shift_more = sh_rd_reg < count_reg;
    assign match_sum  = match_reg + CNT_W'(val_hit);
    assign hit_next_slot = CNT_W'(cmp_idx_reg) + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            sh_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            sh_pend_reg <= sh_pend_next;
        end
        op_reg      <= op_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        match_reg   <= match_next;
        sh_rd_reg   <= sh_rd_next;
        sh_wa_reg   <= sh_wa_next;
        res_reg     <= res_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        match_next    = match_reg;
        sh_rd_next    = sh_rd_reg;
        sh_pend_next  = 1'b0;
        sh_wa_next    = sh_wa_reg;
        res_next      = res_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[ADDR_W-1:0];
        mem_req.wdata = '{key: key_reg, value: val_reg};
        mem_req.raddr = rd_idx_reg[ADDR_W-1:0];
        in_ready      = (state_reg == S_IDLE);
        res_valid     = (state_reg == S_RESP);

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next     = in_op;
                    key_next    = in_key;
                    val_next    = in_value;
                    rd_idx_next = '0;
                    match_next  = '0;
                    res_next    = '0;
                    case (in_op)
                        OP_INSERT, OP_ERASE, OP_LOOKUP, OP_COUNT: begin
                            state_next = S_SCAN;
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            state_next = S_RESP;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                match_next = match_sum;
                if (scan_more && !hit_now) begin
                    mem_req.raddr = rd_idx_reg[ADDR_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = rd_idx_reg[ADDR_W-1:0];
                end
                if (hit_now || !scan_more) begin
                    res_next       = '0;
                    res_next.found = hit_now && (op_reg != OP_COUNT);
                    state_next     = S_RESP;
                    case (op_reg)
                        OP_INSERT: begin
                            if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                                res_next.status = ST_FULL;
                            end else if (hit_now) begin
                                res_next.status = ST_PRESENT;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = count_reg[ADDR_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_ERASE: begin
                            if (!hit_now) begin
                                res_next.status = ST_ABSENT;
                            end else if (hit_next_slot < count_reg) begin
                                // close the gap: later entries move down one slot
                                sh_rd_next = hit_next_slot;
                                state_next = S_SHIFT;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_LOOKUP: begin
                            if (hit_now) begin
                                res_next.read_value = mem_rdata.value;
                            end else begin
                                res_next.status = ST_ABSENT;
                            end
                        end
                        OP_COUNT: begin
                            res_next.match_count = sat_cnt(match_sum);
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                if (shift_more) begin
                    mem_req.raddr = sh_rd_reg[ADDR_W-1:0];
                    sh_rd_next    = sh_rd_reg + CNT_W'(1);
                    sh_pend_next  = 1'b1;
                    sh_wa_next    = sh_rd_reg[ADDR_W-1:0] - ADDR_W'(1);
                end
                if (sh_pend_reg) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = sh_wa_reg;
                    mem_req.wdata = mem_rdata;
                end
                if (!shift_more && !sh_pend_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end

            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg != S_RESP) begin
            res_next.occupancy = sat_cnt(count_next);
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> rtl/key_value_table.sv
// a request scans the stored entries in order behind the registered memory read; insert, erase
//   and lookup stop at the first key match, an erase then shifts the later entries down a slot,
//   clear scans none; the block works on one request at a time
// results sit in an output register, so the next request is taken while one waits
// reset (aresetn low, synchronous) empties the table and drops pending beats;
//   the entry memory itself is not swept
`default_nettype none

module key_value_table import kvt_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,  // lookup_key[63:0], entry_value[95:64]
    input  wire logic [2:0]  s_tuser,  // operation[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,  // read_value[31:0], match_count[37:32],
                                       // occupancy[43:38], zero[47:44]
    output logic      [2:0]  m_tuser   // status[1:0], found[2]
);

    mem_req_t mem_req;
    entry_t   mem_rdata;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic    out_valid_reg;
    result_t out_res_reg;

    kvt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_key    (s_tdata[KEY_BITS-1:0]),
        .in_value  (s_tdata[95:64]),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    kvt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .clk   (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.occupancy, out_res_reg.match_count,
                       out_res_reg.read_value};
    assign m_tuser  = {out_res_reg.found, out_res_reg.status};

endmodule

`default_nettype wire

>>> rtl/kvt_checker.sv
`default_nettype none

module kvt_checker import kvt_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [95:0] s_tdata,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // no result beat survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[43:38]) <= TABLE_DEPTH)
        else $error("occupancy above table depth");

    a_match_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[37:32] <= m_tdata[43:38])
        else $error("match count above occupancy");

    a_status_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser[1:0] != ST_PRESENT) || m_tuser[2])
                  && ((m_tuser[1:0] != ST_ABSENT) || (!m_tuser[2] && m_tdata[31:0] == 32'd0)))
        else $error("status and found disagree");

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);

`default_nettype wire

>>> tb/key_value_table_test.sv
`timescale 1ns / 100ps

module key_value_table_test;
    import kvt_pkg::*;

    localparam int KEY_POOL_SIZE   = 40;
    localparam int VAL_POOL_SIZE   = 8;
    localparam int PHASE_ITEMS     = 150;
    localparam int PHASE_COUNT     = 9;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_COUNT + 3'd1;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;
    typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    // shadow of the table; works out the response of every accepted request
    class kv_scoreboard;
        logic [KEY_BITS-1:0] keys [TABLE_DEPTH];
        logic [VAL_W-1:0]    vals [TABLE_DEPTH];
        int unsigned         used;
        result_t             expected_q [$];
        int unsigned         n_requests, n_checked, n_mismatches;
        int unsigned         n_full, n_present, n_absent, n_count_hits, peak_used;

        function int slot_of(logic [KEY_BITS-1:0] key);
            for (int i = 0; i < used; i++) begin
                if (keys[i] == key) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void note(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
                           logic [VAL_W-1:0] val);
            result_t     r;
            int          slot;
            int unsigned hits;
            r    = '0;
            hits = 0;
            slot = slot_of(key);
            case (op)
                OP_INSERT: begin
                    r.found = (slot >= 0);
                    if (used >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else if (slot >= 0) begin
                        r.status = ST_PRESENT;
                    end else begin
                        keys[used] = key;
                        vals[used] = val;
                        used++;
                    end
                end
                OP_ERASE: begin
                    if (slot >= 0) begin
                        r.found = 1'b1;
                        // later entries close the gap, order kept
                        for (int i = slot; i + 1 < used; i++) begin
                            keys[i] = keys[i+1];
                            vals[i] = vals[i+1];
                        end
                        used--;
                    end else begin
                        r.status = ST_ABSENT;
                    end
                end
                OP_CLEAR: begin
                    used = 0;
                end
                OP_LOOKUP: begin
                    if (slot >= 0) begin
                        r.found      = 1'b1;
                        r.read_value = vals[slot];
                    end else begin
                        r.status = ST_ABSENT;
                    end
                end
                OP_COUNT: begin
                    for (int i = 0; i < used; i++) begin
                        if (vals[i] == val) begin
                            hits++;
                        end
                    end
                end
                default: begin
                end
            endcase
            r.match_count = OUT_CNT_W'((hits > OUT_CNT_MAX) ? OUT_CNT_MAX : hits);
            r.occupancy   = OUT_CNT_W'((used > OUT_CNT_MAX) ? OUT_CNT_MAX : used);
            if (r.status == ST_FULL) n_full++;
            if (r.status == ST_PRESENT) n_present++;
            if (r.status == ST_ABSENT) n_absent++;
            if (hits != 0) n_count_hits++;
            if (used > peak_used) peak_used = used;
            n_requests++;
            expected_q.push_back(r);
        endfunction

        function void check(result_t got);
            result_t exp;
            if (expected_q.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= MAX_REPORTS) begin
                    $display("unexpected result beat: status %0d found %0d occupancy %0d",
                             got.status, got.found, got.occupancy);
                end
                return;
            end
            exp = expected_q.pop_front();
            n_checked++;
            if (got.status !== exp.status || got.found !== exp.found ||
                got.read_value !== exp.read_value ||
                got.match_count !== exp.match_count ||
                got.occupancy !== exp.occupancy) begin
                n_mismatches++;
                if (n_mismatches <= MAX_REPORTS) begin
                    $display("mismatch on result %0d:", n_checked);
                    $display("  expected status %0d found %0d value %0d count %0d occ %0d",
                             exp.status, exp.found, $signed(exp.read_value),
                             exp.match_count, exp.occupancy);
                    $display("  actual   status %0d found %0d value %0d count %0d occ %0d",
                             got.status, got.found, $signed(got.read_value),
                             got.match_count, got.occupancy);
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    kv_scoreboard board = new();

    logic [KEY_BITS-1:0] key_pool [KEY_POOL_SIZE];
    logic [VAL_W-1:0]    val_pool [VAL_POOL_SIZE];
    int                  burst_left   = 0;
    bit                  rx_hold_req  = 1'b0;
    int unsigned         n_holds      = 0;
    int unsigned         idle_cycles  = 0;

    key_value_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status      = m_tuser[1:0];
            got.found       = m_tuser[2];
            got.read_value  = m_tdata[31:0];
            got.match_count = m_tdata[37:32];
            got.occupancy   = m_tdata[43:38];
            board.check(got);
        end
    end

    // nothing accepted on either side for too long means the block hung
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result side backpressure, mode changes every stretch
    initial begin : result_sink
        rx_mode_t mode;
        int       span;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge aclk);
                if (rx_hold_req) begin
                    m_tready = 1'b0;
                    repeat (RX_HOLD_CYCLES) @(negedge aclk);
                    rx_hold_req = 1'b0;
                    n_holds++;
                end
                case (mode)
                    RX_STREAM: m_tready = 1'b1;
                    RX_COIN:   m_tready = 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                    default:   m_tready = ~m_tready;
                endcase
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic push_request(input logic [OP_W-1:0] op, input logic [KEY_BITS-1:0] key,
                                input logic [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tuser  = op;
        s_tdata  = {val, key};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note(op, key, val);
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_tvalid = 1'b0;
        while (board.expected_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct) begin
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        end
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 70) begin
            return val_pool[$urandom_range(0, VAL_POOL_SIZE - 1)];
        end
        return $urandom;
    endfunction

    task automatic random_request(input mix_t mix);
        int              roll;
        logic [OP_W-1:0] op;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (roll < 70) op = OP_INSERT;
                else if (roll < 82) op = OP_LOOKUP;
                else if (roll < 90) op = OP_COUNT;
                else if (roll < 97) op = OP_ERASE;
                else op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            end
            MIX_BALANCED: begin
                if (roll < 35) op = OP_INSERT;
                else if (roll < 60) op = OP_ERASE;
                else if (roll < 80) op = OP_LOOKUP;
                else if (roll < 92) op = OP_COUNT;
                else if (roll < 97) op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
                else op = OP_CLEAR;
            end
            default: begin
                if (roll < 55) op = OP_ERASE;
                else if (roll < 75) op = OP_LOOKUP;
                else if (roll < 90) op = OP_INSERT;
                else if (roll < 98) op = OP_COUNT;
                else op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            end
        endcase
        push_request(op, pick_key((op == OP_INSERT) ? 85 : 80), pick_value());
    endtask

    initial begin : stimulus
        logic [KEY_BITS-1:0] miss_key;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end
        val_pool[0] = 32'h0000_0000;
        val_pool[1] = 32'h8000_0000;
        val_pool[2] = 32'h7fff_ffff;
        val_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < VAL_POOL_SIZE; i++) begin
            val_pool[i] = $urandom;
        end
        miss_key = {$urandom, $urandom};

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // empty table corners
        push_request(OP_LOOKUP, key_pool[0], '0);
        push_request(OP_ERASE,  key_pool[0], '0);
        push_request(OP_COUNT,  key_pool[0], '0);
        // extreme keys and values, duplicate insert
        push_request(OP_INSERT, key_pool[0], val_pool[1]);
        push_request(OP_INSERT, key_pool[1], val_pool[2]);
        push_request(OP_INSERT, key_pool[2], val_pool[1]);
        push_request(OP_INSERT, key_pool[0], 32'd5);
        push_request(OP_LOOKUP, key_pool[0], '0);
        push_request(OP_LOOKUP, key_pool[1], '0);
        push_request(OP_LOOKUP, miss_key,    '0);
        push_request(OP_COUNT,  miss_key,    val_pool[1]);
        push_request(OP_COUNT,  miss_key,    val_pool[2]);
        // erase of the oldest entry shifts the rest down
        push_request(OP_ERASE,  key_pool[0], '0);
        push_request(OP_LOOKUP, key_pool[2], '0);
        push_request(OP_ERASE,  key_pool[0], '0);
        for (int k = int'(OP_FIRST_UNUSED); k <= int'(OP_LAST_UNUSED); k++) begin
            push_request(OP_W'(k), {$urandom, $urandom}, $urandom);
        end
        push_request(OP_CLEAR,  key_pool[3], val_pool[3]);
        push_request(OP_LOOKUP, key_pool[1], '0);
        push_request(OP_COUNT,  miss_key,    val_pool[1]);
        push_request(OP_INSERT, key_pool[1], val_pool[3]);
        push_request(OP_ERASE,  key_pool[1], '0);
        wait_all_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 1 || phase == 5) begin
                rx_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request(mix_t'(phase % 3));
            end
            if (phase % 2 == 0) begin
                wait_all_results();
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d of %0d requests checked, peak occupancy %0d, %0d full, %0d duplicates",
                 board.n_checked, board.n_requests, board.peak_used, board.n_full,
                 board.n_present);
        $display("%0d key misses, %0d nonzero counts, %0d long result stalls, %0d mismatches",
                 board.n_absent, board.n_count_hits, n_holds, board.n_mismatches);
        if (board.n_mismatches == 0 && board.expected_q.size() == 0 &&
            board.n_checked == board.n_requests) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
